FILE: design/utfp_pkg.sv
// Shared constants and types for the time-frame parser.
package utfp_pkg;

    localparam int FRAME_LEN   = 28;
    localparam int KEPT_BYTES  = 24;
    localparam int COUNT_W     = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int RESULT_W    = 192;

    localparam logic [COUNT_W-1:0] POS_IDLE      = COUNT_W'(FRAME_LEN);
    localparam logic [COUNT_W-1:0] POS_SUM_FIRST = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_SUM_LAST  = COUNT_W'(FRAME_LEN - 3);
    localparam logic [COUNT_W-1:0] POS_CK_A      = COUNT_W'(FRAME_LEN - 2);
    localparam logic [COUNT_W-1:0] POS_CK_B      = COUNT_W'(FRAME_LEN - 1);

    typedef enum logic
    {
        ENT_KEEP,
        ENT_EMIT
    } entry_kind_t;

    typedef struct packed
    {
        entry_kind_t kind;
        logic [7:0]  data;
    } queue_entry_t;

    typedef struct packed
    {
        logic         valid;
        queue_entry_t entry;
    } queue_port_t;

endpackage

FILE: design/utfp_front.sv
// Front end: byte counting, Fletcher sums and request classification.
module utfp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,  // [7:0] rx_byte
    input  logic                 s_tuser,  // [0] frame_start
    input  logic                 q_full,
    output utfp_pkg::queue_port_t push
);
    import utfp_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         sum_a_reg, sum_a_next;
    logic [7:0]         sum_b_reg, sum_b_next;
    logic               matched_reg, matched_next;

    logic               accept;
    logic [COUNT_W-1:0] pos;
    logic [7:0]         sum_a_eff;
    logic [7:0]         sum_b_eff;
    logic               matched_eff;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        pos         = s_tuser ? '0 : count_reg;
        sum_a_eff   = s_tuser ? '0 : sum_a_reg;
        sum_b_eff   = s_tuser ? '0 : sum_b_reg;
        matched_eff = s_tuser ? 1'b0 : matched_reg;

        count_next   = count_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        matched_next = matched_reg;

        push.valid      = 1'b0;
        push.entry.kind = ENT_KEEP;
        push.entry.data = s_tdata;

        if (accept)
        begin
            count_next   = pos;
            sum_a_next   = sum_a_eff;
            sum_b_next   = sum_b_eff;
            matched_next = matched_eff;
            if (pos < POS_IDLE)
            begin
                count_next = pos + COUNT_W'(1);
                if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST)
                begin
                    sum_a_next = sum_a_eff + s_tdata;
                    sum_b_next = sum_b_eff + sum_a_next;
                    push.valid = 1'b1;
                end
                else if (pos == POS_CK_A)
                begin
                    matched_next = (sum_a_eff == s_tdata);
                end
                else if (pos == POS_CK_B)
                begin
                    // commit the frame only when both check bytes agree
                    if (matched_eff && sum_b_eff == s_tdata)
                    begin
                        push.valid      = 1'b1;
                        push.entry.kind = ENT_EMIT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= POS_IDLE;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            matched_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            matched_reg <= matched_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_IDLE)
        else $error("byte counter out of range");
    a_emit_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.entry.kind == ENT_EMIT) |=> (count_reg == POS_IDLE))
        else $error("commit request did not end the frame");
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (s_tvalid && s_tready))
        else $error("request pushed without an accepted byte");
`endif

endmodule

FILE: design/utfp_queue.sv
// Short request queue between the front end and the back end.
module utfp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  utfp_pkg::queue_port_t push,
    output logic                  full,
    output utfp_pkg::queue_port_t head,
    input  logic                  pop
);
    import utfp_pkg::*;

    queue_entry_t           entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("request pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");
`endif

endmodule

FILE: design/utfp_back.sv
// Back end: frame byte store, field decode and result register.
module utfp_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  utfp_pkg::queue_port_t            head,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utfp_pkg::RESULT_W-1:0]    m_tdata
);
    import utfp_pkg::*;

    logic [7:0]          store_reg [KEPT_BYTES];
    logic                out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0] out_data_reg;
    logic [RESULT_W-1:0] decoded;
    logic                pop_keep;
    logic                pop_emit;

    // store_reg[k] holds frame byte k+2 once a whole frame has shifted in
    always_comb
    begin
        decoded = {store_reg[23],                                   // valid_flags
                   store_reg[22], store_reg[21], store_reg[20],     // sec, min, hour
                   store_reg[19], store_reg[18],                    // day, month
                   store_reg[17], store_reg[16],                    // year
                   store_reg[15], store_reg[14], store_reg[13], store_reg[12],
                   store_reg[11], store_reg[10], store_reg[9],  store_reg[8],
                   store_reg[7],  store_reg[6],  store_reg[5],  store_reg[4],
                   store_reg[3],  store_reg[2],                     // length
                   store_reg[0],  store_reg[1]};                    // class, id
    end

    assign pop_keep = head.valid && head.entry.kind == ENT_KEEP;
    assign pop_emit = head.valid && head.entry.kind == ENT_EMIT
                      && (!out_valid_reg || m_tready);
    assign pop      = pop_keep || pop_emit;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_emit)
        begin
            out_data_reg <= decoded;
        end
        // advance the byte line
        if (pop_keep)
        begin
            for (int i = 0; i < KEPT_BYTES - 1; i++)
            begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[KEPT_BYTES-1] <= head.entry.data;
        end
    end

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop_emit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before delivery");
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop_emit |=> m_tvalid)
        else $error("committed frame not presented");
    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop_keep && pop_emit))
        else $error("two requests taken at once");
`endif

endmodule

FILE: design/ubx_time_frame_parser_unit.sv
// Top level of the time-frame parser with Fletcher check.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] rx_byte, tuser frame_start
//  m_*      out  m_tvalid/m_tready  tdata[191:0] decoded time fields
//
// One byte is taken per cycle unless the request queue is full; a frame's
// commit passes the queue and loads the output register when it is free.
// The front end stalls only when the four-entry request queue fills, which
// happens while a result waits on m_tready and the next frame commits.
// Reset is asynchronous; the frame byte store needs no clearing.
module ubx_time_frame_parser_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    input  logic                          s_tuser,  // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] class_id, [31:16] payload_length, [63:32] time_of_week,
    // [95:64] time_accuracy, [127:96] nanoseconds, [143:128] year,
    // [151:144] month, [159:152] day, [167:160] hour, [175:168] minute,
    // [183:176] second, [191:184] valid_flags
    output logic [utfp_pkg::RESULT_W-1:0] m_tdata
);
    import utfp_pkg::*;

    queue_port_t push;
    queue_port_t head;
    logic        q_full;
    logic        pop;

    utfp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push)
    );

    utfp_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    utfp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: tb/ubx_time_frame_parser_unit_test.sv
// Self-checking testbench for the time-frame parser with Fletcher check.
`timescale 1ns / 100ps

module ubx_time_frame_parser_unit_test;

    import utfp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_OFF    = 400;
    localparam int RANDOM_BYTES = 900;
    localparam int MAX_REPORTS = 40;

    // Decoded time fields; the first member lands in the highest bits.
    typedef struct packed
    {
        logic [7:0]  valid_flags;
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] year;
        logic [31:0] nanoseconds;  // two's complement
        logic [31:0] time_accuracy;
        logic [31:0] time_of_week;
        logic [15:0] payload_length;
        logic [15:0] class_id;
    } time_fields_t;

    typedef enum
    {
        FR_GOOD,
        FR_BAD_A,
        FR_BAD_B,
        FR_BAD_BOTH
    } frame_fault_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [RESULT_W-1:0] m_tdata;

    // Parser state mirrored on the accepted byte stream
    logic [COUNT_W-1:0]  next_pos;
    logic [7:0]          run_a;
    logic [7:0]          run_b;
    logic                ck_a_equal;
    logic [7:0]          kept [KEPT_BYTES];

    time_fields_t        decoded_q [$];
    int                  err_count;
    int                  result_count;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  hold_cycles;
    int                  frame_bytes_sent;

    ubx_time_frame_parser_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      result_count, name, got, want));
    endtask

    // Advance the mirrored parser by one accepted byte; queue a decode on a good frame.
    task automatic parse_frame_byte(input logic [7:0] b, input logic start);
        logic [COUNT_W-1:0] pos;
        time_fields_t       d;
        if (start)
        begin
            next_pos   = '0;
            run_a      = '0;
            run_b      = '0;
            ck_a_equal = 1'b0;
        end
        if (next_pos < FRAME_LEN)
        begin
            pos      = next_pos;
            next_pos = next_pos + COUNT_W'(1);
            if (pos >= 2 && pos <= FRAME_LEN - 3)
            begin
                run_a                     = run_a + b;
                run_b                     = run_b + run_a;
                kept[pos - COUNT_W'(2)]   = b;
            end
            else if (pos == FRAME_LEN - 2)
                ck_a_equal = (run_a == b);
            else if (pos == FRAME_LEN - 1 && ck_a_equal && run_b == b)
            begin
                d.class_id       = {kept[0], kept[1]};
                d.payload_length = {kept[3], kept[2]};
                d.time_of_week   = {kept[7], kept[6], kept[5], kept[4]};
                d.time_accuracy  = {kept[11], kept[10], kept[9], kept[8]};
                d.nanoseconds    = {kept[15], kept[14], kept[13], kept[12]};
                d.year           = {kept[17], kept[16]};
                d.month          = kept[18];
                d.day            = kept[19];
                d.hour           = kept[20];
                d.minute         = kept[21];
                d.second         = kept[22];
                d.valid_flags    = kept[23];
                decoded_q.push_back(d);
            end
        end
    endtask

    // Offer one byte after a random gap; return at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom());
            s_tuser  <= 1'($urandom());
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_frame_byte(b, start);
    endtask

    task automatic send_frame(input time_fields_t f, input frame_fault_t fault,
                              input int cut = FRAME_LEN,
                              input logic [7:0] sync0 = 8'hB5,
                              input logic [7:0] sync1 = 8'h62);
        logic [7:0] fr [FRAME_LEN];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        fr[0]  = sync0;
        fr[1]  = sync1;
        fr[2]  = f.class_id[15:8];
        fr[3]  = f.class_id[7:0];
        for (int i = 0; i < 2; i++)
        begin
            fr[4 + i]  = f.payload_length[8*i +: 8];
            fr[18 + i] = f.year[8*i +: 8];
        end
        for (int i = 0; i < 4; i++)
        begin
            fr[6 + i]  = f.time_of_week[8*i +: 8];
            fr[10 + i] = f.time_accuracy[8*i +: 8];
            fr[14 + i] = f.nanoseconds[8*i +: 8];
        end
        fr[20] = f.month;
        fr[21] = f.day;
        fr[22] = f.hour;
        fr[23] = f.minute;
        fr[24] = f.second;
        fr[25] = f.valid_flags;
        ck_a = '0;
        ck_b = '0;
        for (int i = 2; i <= FRAME_LEN - 3; i++)
        begin
            ck_a = ck_a + fr[i];
            ck_b = ck_b + ck_a;
        end
        fr[26] = ck_a;
        fr[27] = ck_b;
        if (fault == FR_BAD_A || fault == FR_BAD_BOTH)
            fr[26] = ck_a ^ 8'($urandom_range(1, 255));
        if (fault == FR_BAD_B || fault == FR_BAD_BOTH)
            fr[27] = ck_b ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < cut; i++)
            send_byte(fr[i], i == 0);
        frame_bytes_sent += cut;
    endtask

    function automatic time_fields_t random_fields();
        return time_fields_t'({$urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom()});
    endfunction

    task automatic test_directed();
        time_fields_t f;
        // ignore bytes while idle after reset
        send_byte(8'hB5, 1'b0);
        send_byte(8'h62, 1'b0);
        send_frame(time_fields_t'('0), FR_GOOD);
        send_frame(time_fields_t'('1), FR_GOOD);
        f = random_fields();
        f.nanoseconds = 32'h8000_0000;
        send_frame(f, FR_GOOD);
        f.nanoseconds = 32'h7FFF_FFFF;
        f.valid_flags = 8'h04;
        send_frame(f, FR_GOOD);
        // sync and header are not checked
        send_frame(random_fields(), FR_GOOD, FRAME_LEN, 8'h00, 8'hFF);
        send_frame(random_fields(), FR_BAD_A);
        send_frame(random_fields(), FR_BAD_B);
        send_frame(random_fields(), FR_BAD_BOTH);
        send_frame(random_fields(), FR_GOOD);
        // drop trailing bytes after a complete frame
        send_byte(8'hB5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart mid-frame, partial frame dropped
        send_frame(random_fields(), FR_GOOD, 15);
        send_frame(random_fields(), FR_GOOD);
    endtask

    task automatic test_random_traffic();
        int pick;
        int start_bytes;
        start_bytes = frame_bytes_sent;
        while (frame_bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(9) == 0)
                    send_frame(random_fields(), FR_GOOD, FRAME_LEN,
                               8'($urandom()), 8'($urandom()));
                else
                    send_frame(random_fields(), FR_GOOD);
            end
            else if (pick < 82)
                send_frame(random_fields(), frame_fault_t'($urandom_range(1, 3)));
            else if (pick < 90)
                send_frame(random_fields(), FR_GOOD, $urandom_range(1, FRAME_LEN - 1));
            else
            begin
                // noise: stray bytes, now and then a bare start flag
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom()), $urandom_range(7) == 0);
            end
        end
    endtask

    task automatic test_back_pressure();
        tx_idle_pct = 0;
        hold_cycles = HOLD_OFF;
        repeat (10)
            send_frame(random_fields(), FR_GOOD);
        tx_idle_pct = 7;
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (12)
            send_frame(random_fields(), FR_GOOD);
        tx_idle_pct = 7;
        rx_idle_pct = 7;
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
        if (err_count == 0)
            $display("ubx_time_frame_parser_unit_test: PASS");
        else
            $display("ubx_time_frame_parser_unit_test: FAIL");
        $finish;
    endtask

    initial
    begin
        err_count        = 0;
        result_count     = 0;
        tx_idle_pct      = 7;
        rx_idle_pct      = 7;
        hold_cycles      = 0;
        frame_bytes_sent = 0;
        next_pos         = COUNT_W'(FRAME_LEN);
        run_a            = '0;
        run_b            = '0;
        ck_a_equal       = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_back_pressure();
        test_full_rate();
        finish_run();
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : result_monitor
        time_fields_t got;
        time_fields_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = time_fields_t'(m_tdata);
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("class_id", 32'(got.class_id), 32'(want.class_id));
                    check_field("payload_length", 32'(got.payload_length),
                                32'(want.payload_length));
                    check_field("time_of_week", got.time_of_week, want.time_of_week);
                    check_field("time_accuracy", got.time_accuracy, want.time_accuracy);
                    check_field("nanoseconds", got.nanoseconds, want.nanoseconds);
                    check_field("year", 32'(got.year), 32'(want.year));
                    check_field("month", 32'(got.month), 32'(want.month));
                    check_field("day", 32'(got.day), 32'(want.day));
                    check_field("hour", 32'(got.hour), 32'(want.hour));
                    check_field("minute", 32'(got.minute), 32'(want.minute));
                    check_field("second", 32'(got.second), 32'(want.second));
                    check_field("valid_flags", 32'(got.valid_flags),
                                32'(want.valid_flags));
                end
                result_count++;
            end
        end
    end

    // End the run when neither side moves a request for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("ubx_time_frame_parser_unit_test: FAIL");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
design/utfp_pkg.sv
design/utfp_front.sv
design/utfp_queue.sv
design/utfp_back.sv
design/ubx_time_frame_parser_unit.sv
tb/ubx_time_frame_parser_unit_test.sv
